>>> rtl/weighted_2d_histogram_macros.svh
// assertion macros used by the histogram top level
`ifndef WEIGHTED_2D_HISTOGRAM_MACROS_SVH
`define WEIGHTED_2D_HISTOGRAM_MACROS_SVH

// same-cycle implication, disabled during reset
`define W2H_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define W2H_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/w2h_pkg.sv
// shared widths, codes and reset values of the weighted 2d histogram
`timescale 1ns / 1ps

package w2h_pkg;

    localparam int T_BINS_DEF    = 256;
    localparam int R_BINS_DEF    = 32;
    localparam int SUM_WIDTH_DEF = 48;

    localparam int TEMP_W    = 20;
    localparam int RATIO_W   = 16;
    localparam int TWIDTH_W  = 19;
    localparam int TCOUNT_W  = 9;
    localparam int RCOUNT_W  = 6;
    localparam int WEIGHT_W  = 16;
    localparam int PROD_W    = TEMP_W + WEIGHT_W;
    localparam int TIDX_W    = 8;
    localparam int RIDX_W    = 5;
    localparam int OUT_W     = 48;
    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 3;

    localparam logic OP_ACC  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_T_LOWER     = 3'd0,
        CFG_T_WIDTH     = 3'd1,
        CFG_T_BIN_COUNT = 3'd2,
        CFG_R_LOWER     = 3'd3,
        CFG_R_WIDTH     = 3'd4,
        CFG_R_BIN_COUNT = 3'd5,
        CFG_WEIGHT      = 3'd6
    } t_cfg_idx;

    localparam logic signed [TEMP_W-1:0] T_LOWER_RST     = -20'sd15998;
    localparam logic [TWIDTH_W-1:0]      T_WIDTH_RST     = 19'd64;
    localparam logic [TCOUNT_W-1:0]      T_BIN_COUNT_RST = 9'd254;
    localparam logic [RATIO_W-1:0]       R_LOWER_RST     = 16'd0;
    localparam logic [RATIO_W-1:0]       R_WIDTH_RST     = 16'd410;
    localparam logic [RCOUNT_W-1:0]      R_BIN_COUNT_RST = 6'd20;
    localparam logic [WEIGHT_W-1:0]      WEIGHT_RST      = 16'd256;

endpackage

>>> rtl/w2h_ser_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module w2h_ser_div #(
    parameter int N = 20,
    parameter int D = 19
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [N-1:0] i_dividend,
    input  logic [D-1:0] i_divisor,
    output logic [N-1:0] o_quotient,
    output logic         o_busy
);

    localparam int CW = $clog2(N + 1);

    logic [N-1:0]  r_quo;
    logic [D-1:0]  r_rem;
    logic [D-1:0]  r_div;
    logic [CW-1:0] r_cnt;
    logic          r_busy;

    logic [D:0]    w_trial;
    logic [D:0]    w_diff;
    logic          w_fits;
    logic [D-1:0]  w_rem_next;
    logic [N:0]    w_quo_sh;

    always_comb begin
        w_trial    = {r_rem, r_quo[N-1]};
        w_diff     = w_trial - {1'b0, r_div};
        w_fits     = (w_trial >= {1'b0, r_div});
        w_rem_next = w_fits ? w_diff[D-1:0] : w_trial[D-1:0];
        w_quo_sh   = {r_quo, w_fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_quo  <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
            r_cnt  <= CW'(N);
            r_busy <= 1'b1;
        end else if (r_busy) begin
            r_quo <= w_quo_sh[N-1:0];
            r_rem <= w_rem_next;
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_quotient = r_quo;
    assign o_busy     = r_busy;

endmodule

>>> rtl/w2h_ser_mul.sv
// shift-add multiplier, one weight bit per cycle
`timescale 1ns / 1ps

module w2h_ser_mul
    import w2h_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [TEMP_W-1:0] i_temperature,
    input  logic [WEIGHT_W-1:0]      i_weight,
    output logic signed [PROD_W-1:0] o_product,
    output logic                     o_busy
);

    localparam int CW = $clog2(WEIGHT_W + 1);

    logic signed [PROD_W-1:0] r_mcand;
    logic signed [PROD_W-1:0] r_acc;
    logic [WEIGHT_W-1:0]      r_mplier;
    logic [CW-1:0]            r_cnt;
    logic                     r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_mcand  <= PROD_W'(i_temperature);
            r_mplier <= i_weight;
            r_acc    <= '0;
            r_cnt    <= CW'(WEIGHT_W);
            r_busy   <= 1'b1;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= r_mcand <<< 1;
            r_mplier <= r_mplier >> 1;
            r_cnt    <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_product = r_acc;
    assign o_busy    = r_busy;

endmodule

>>> rtl/weighted_2d_histogram.sv
// weighted 2d histogram over temperature and ratio, top level
//
// Each input beat either accumulates a sample or reads one bin. For an
// accumulate beat the temperature bin is floor((t - t_lower) / t_width) and
// the ratio bin floor((r - r_lower) / r_width); both quotients come out of
// bit-serial restoring dividers running side by side, while a shift-add
// multiplier forms temperature times weight one weight bit per cycle. The
// 20-bit temperature divider is the slowest unit and sets the pace: an
// accumulate beat runs acceptance, the divider steps, lookup, memory read,
// saturating add and output load; a read beat runs acceptance, memory read
// and output load. A sample below a lower edge, with a zero width or
// landing beyond the bin count in use gives a result beat of all zeros. Bin
// sums live in a T_BINS x R_BINS single-port-write memory and clip at the
// signed SUM_WIDTH limits, flagged by saturated. After reset the block sweeps
// the memory to zero, one entry per cycle (T_BINS * R_BINS entries, 8192 at
// the defaults), and holds input stall high meanwhile; configuration writes
// are taken at any time and should be made while no beat is in flight.
`timescale 1ns / 1ps
`include "weighted_2d_histogram_macros.svh"

module weighted_2d_histogram
    import w2h_pkg::*;
#(
    parameter int T_BINS    = T_BINS_DEF,
    parameter int R_BINS    = R_BINS_DEF,
    parameter int SUM_WIDTH = SUM_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration write port
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data,
    // input channel
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_operation,
    input  logic signed [TEMP_W-1:0] i_temperature,
    input  logic [RATIO_W-1:0]       i_ratio,
    input  logic [TIDX_W-1:0]        i_t_index,
    input  logic [RIDX_W-1:0]        i_r_index,
    // output channel
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [OUT_W-1:0]  o_bin_value,
    output logic                     o_landed,
    output logic                     o_saturated
);

    localparam int DEPTH = T_BINS * R_BINS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = SUM_WIDTH;
    // extended width that holds any sum plus any product without wrap
    localparam int EW    = ((SW > PROD_W) ? SW : PROD_W) + 1;
    localparam int CMP_W = 32;

    localparam logic [AW-1:0]         LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [AW-1:0]         R_STRIDE  = AW'(R_BINS);
    localparam logic [TEMP_W-1:0]     T_CAP     = TEMP_W'(T_BINS);
    localparam logic [RATIO_W-1:0]    R_CAP     = RATIO_W'(R_BINS);
    localparam logic signed [EW-1:0]  SUM_MAX   = EW'((65'd1 << (SW - 1)) - 65'd1);
    localparam logic signed [EW-1:0]  SUM_MIN   = ~SUM_MAX;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CALC,
        S_RD,
        S_ADD,
        S_PUSH
    } t_state;

    // configuration registers
    logic signed [TEMP_W-1:0] r_t_lower;
    logic [TWIDTH_W-1:0]      r_t_width;
    logic [TCOUNT_W-1:0]      r_t_bin_count;
    logic [RATIO_W-1:0]       r_r_lower;
    logic [RATIO_W-1:0]       r_r_width;
    logic [RCOUNT_W-1:0]      r_r_bin_count;
    logic [WEIGHT_W-1:0]      r_weight;

    // sequencer and item state
    t_state                   r_state;
    logic [AW-1:0]            r_clr_addr;
    logic [AW-1:0]            r_addr;
    logic                     r_op;
    logic signed [SW-1:0]     r_res_value;
    logic                     r_res_landed;
    logic                     r_res_sat;

    // output register
    logic                     r_out_valid;
    logic signed [OUT_W-1:0]  r_out_value;
    logic                     r_out_landed;
    logic                     r_out_sat;

    // bin memory
    logic signed [SW-1:0]     r_bin_mem [DEPTH];
    logic signed [SW-1:0]     r_mem_q;

    logic                     w_accept;
    logic                     w_acc_reject;
    logic                     w_unit_start;
    logic                     w_units_busy;
    logic                     w_t_busy;
    logic                     w_r_busy;
    logic                     w_m_busy;
    logic [TEMP_W:0]          w_t_diff;
    logic [RATIO_W-1:0]       w_r_diff;
    logic [TEMP_W-1:0]        w_t_quo;
    logic [RATIO_W-1:0]       w_r_quo;
    logic signed [PROD_W-1:0] w_prod;
    logic [TEMP_W-1:0]        w_t_eff;
    logic [RATIO_W-1:0]       w_r_eff;
    logic                     w_lands;
    logic [AW-1:0]            w_acc_addr;
    logic [AW-1:0]            w_rd_addr;
    logic                     w_rd_in_range;
    logic signed [EW-1:0]     w_sum_ext;
    logic signed [SW-1:0]     w_new_sum;
    logic                     w_clip;
    logic signed [63:0]       w_sum64;
    logic                     w_mem_we;
    logic                     w_mem_re;
    logic [AW-1:0]            w_mem_waddr;
    logic signed [SW-1:0]     w_mem_wdata;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_lower     <= T_LOWER_RST;
            r_t_width     <= T_WIDTH_RST;
            r_t_bin_count <= T_BIN_COUNT_RST;
            r_r_lower     <= R_LOWER_RST;
            r_r_width     <= R_WIDTH_RST;
            r_r_bin_count <= R_BIN_COUNT_RST;
            r_weight      <= WEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_T_LOWER:     r_t_lower     <= i_cfg_data[TEMP_W-1:0];
                CFG_T_WIDTH:     r_t_width     <= i_cfg_data[TWIDTH_W-1:0];
                CFG_T_BIN_COUNT: r_t_bin_count <= i_cfg_data[TCOUNT_W-1:0];
                CFG_R_LOWER:     r_r_lower     <= i_cfg_data[RATIO_W-1:0];
                CFG_R_WIDTH:     r_r_width     <= i_cfg_data[RATIO_W-1:0];
                CFG_R_BIN_COUNT: r_r_bin_count <= i_cfg_data[RCOUNT_W-1:0];
                CFG_WEIGHT:      r_weight      <= i_cfg_data[WEIGHT_W-1:0];
                default: begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    // input side decode
    always_comb begin
        w_accept     = (r_state == S_IDLE) && i_in_valid;
        w_acc_reject = (i_temperature < r_t_lower) || (r_t_width == '0) ||
                       (i_ratio < r_r_lower) || (r_r_width == '0);
        w_unit_start = w_accept && (i_operation == OP_ACC) && !w_acc_reject;
        // never negative once the lower-edge test passes
        w_t_diff     = {i_temperature[TEMP_W-1], i_temperature} -
                       {r_t_lower[TEMP_W-1], r_t_lower};
        w_r_diff     = i_ratio - r_r_lower;
        w_rd_in_range = (CMP_W'(i_t_index) < CMP_W'(T_BINS)) &&
                        (CMP_W'(i_r_index) < CMP_W'(R_BINS));
        w_rd_addr    = AW'(i_t_index) * R_STRIDE + AW'(i_r_index);
    end

    w2h_ser_div #(
        .N (TEMP_W),
        .D (TWIDTH_W)
    ) u_t_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_unit_start),
        .i_dividend (w_t_diff[TEMP_W-1:0]),
        .i_divisor  (r_t_width),
        .o_quotient (w_t_quo),
        .o_busy     (w_t_busy)
    );

    w2h_ser_div #(
        .N (RATIO_W),
        .D (RATIO_W)
    ) u_r_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_unit_start),
        .i_dividend (w_r_diff),
        .i_divisor  (r_r_width),
        .o_quotient (w_r_quo),
        .o_busy     (w_r_busy)
    );

    w2h_ser_mul u_mul (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (w_unit_start),
        .i_temperature (i_temperature),
        .i_weight      (r_weight),
        .o_product     (w_prod),
        .o_busy        (w_m_busy)
    );

    // bin lookup and saturating update
    always_comb begin
        w_units_busy = w_t_busy || w_r_busy || w_m_busy;
        // counts larger than the store act as the store size
        w_t_eff = (TEMP_W'(r_t_bin_count) > T_CAP) ? T_CAP : TEMP_W'(r_t_bin_count);
        w_r_eff = (RATIO_W'(r_r_bin_count) > R_CAP) ? R_CAP : RATIO_W'(r_r_bin_count);
        w_lands = (w_t_quo < w_t_eff) && (w_r_quo < w_r_eff);
        // quotients are in range when used, so the address math cannot wrap
        w_acc_addr = AW'(w_t_quo) * R_STRIDE + AW'(w_r_quo);

        w_sum_ext = EW'(r_mem_q) + EW'(w_prod);
        if (w_sum_ext > SUM_MAX) begin
            w_new_sum = SW'(SUM_MAX);
            w_clip    = 1'b1;
        end else if (w_sum_ext < SUM_MIN) begin
            w_new_sum = SW'(SUM_MIN);
            w_clip    = 1'b1;
        end else begin
            w_new_sum = SW'(w_sum_ext);
            w_clip    = 1'b0;
        end

        w_sum64 = 64'(r_res_value);

        w_mem_we    = (r_state == S_CLEAR) || ((r_state == S_ADD) && (r_op == OP_ACC));
        w_mem_re    = (r_state == S_RD);
        w_mem_waddr = (r_state == S_CLEAR) ? r_clr_addr : r_addr;
        w_mem_wdata = (r_state == S_CLEAR) ? '0 : w_new_sum;
    end

    // bin memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_bin_mem[w_mem_waddr] <= w_mem_wdata;
        end
        if (w_mem_re) begin
            r_mem_q <= r_bin_mem[r_addr];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // the push state reloads the output register itself
            if (r_out_valid && !i_out_stall && (r_state != S_PUSH)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (r_clr_addr == LAST_ADDR) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_clr_addr <= r_clr_addr + AW'(1);
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op         <= i_operation;
                        r_res_value  <= '0;
                        r_res_landed <= 1'b0;
                        r_res_sat    <= 1'b0;
                        if (i_operation == OP_READ) begin
                            r_addr  <= w_rd_addr;
                            r_state <= w_rd_in_range ? S_RD : S_PUSH;
                        end else if (w_acc_reject) begin
                            r_state <= S_PUSH;
                        end else begin
                            r_state <= S_CALC;
                        end
                    end
                end
                S_CALC: begin
                    // wait for both quotients and the product
                    if (!w_units_busy) begin
                        if (w_lands) begin
                            r_addr  <= w_acc_addr;
                            r_state <= S_RD;
                        end else begin
                            r_state <= S_PUSH;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    if (r_op == OP_READ) begin
                        r_res_value <= r_mem_q;
                    end else begin
                        r_res_value  <= w_new_sum;
                        r_res_landed <= 1'b1;
                        r_res_sat    <= w_clip;
                    end
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    // load the output register once it is free
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid  <= 1'b1;
                        r_out_value  <= w_sum64[OUT_W-1:0];
                        r_out_landed <= r_res_landed;
                        r_out_sat    <= r_res_sat;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_bin_value = r_out_value;
    assign o_landed    = r_out_landed;
    assign o_saturated = r_out_sat;

    `W2H_ASSERT_IMPL(a_sat_needs_land, i_clk, i_rst_n, o_out_valid && o_saturated, o_landed, "saturated beat without a landed sample")
    `W2H_ASSERT_NEXT(a_accept_locks_input, i_clk, i_rst_n, w_accept, o_in_stall, "input not stalled after an accepted beat")
    `W2H_ASSERT_IMPL(a_accept_after_clear, i_clk, i_rst_n, w_accept, r_clr_addr == LAST_ADDR, "beat accepted before memory clear finished")
    `W2H_ASSERT_IMPL(a_units_idle_on_read, i_clk, i_rst_n, r_state == S_RD, !w_units_busy, "memory read issued while arithmetic units busy")

endmodule
